>>> hdl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared constants and controller/datapath interface types for the
// minimum spanning cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmst_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam int DEF_WEIGHT_BITS  = 16;

    localparam int NV_W     = 11;
    localparam int VTX_W    = 11;
    localparam int WIN_W    = 16;
    localparam int COST_W   = 32;
    localparam int TAKEN_W  = 10;

    localparam logic [NV_W-1:0] NV_RESET = 11'd1024;

    typedef struct packed {
        logic load;
        logic init_start;
        logic init_step;
        logic blk_setup;
        logic m_step;
        logic blk_next;
        logic pass_end;
        logic k_start;
        logic k_latch;
        logic f_step;
        logic c_start;
        logic c_step;
        logic f_second;
        logic unite;
        logic j_next;
        logic emit;
    } kmst_cmd_t;

    typedef struct packed {
        logic init_done;
        logic empty;
        logic blk_lt_n;
        logic width_lt_n;
        logic merge_last;
        logic j_last;
        logic edge_skip;
        logic par_self;
        logic par_root;
        logic sel;
        logic tree_full;
    } kmst_sts_t;

endpackage

`default_nettype wire

>>> hdl/kmst_ctrl.sv
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: load, parent table init, merge sort passes, union-find walk.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_ctrl
    import kmst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      last_edge,
    input  wire kmst_sts_t sts,
    output kmst_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_INIT  = 15'b000000000000010,
        S_SETUP = 15'b000000000000100,
        S_M_RD  = 15'b000000000001000,
        S_M_CMP = 15'b000000000010000,
        S_BLK   = 15'b000000000100000,
        S_PASS  = 15'b000000001000000,
        S_K_RD  = 15'b000000010000000,
        S_K_CHK = 15'b000000100000000,
        S_F_RD  = 15'b000001000000000,
        S_F_CHK = 15'b000010000000000,
        S_C_RD  = 15'b000100000000000,
        S_C_CHK = 15'b001000000000000,
        S_UNION = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } kmst_state_t;

    kmst_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_EMIT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && last_edge)
                begin
                    cmd.init_start = 1'b1;
                    state_next     = S_INIT;
                end
            end
            S_INIT:
            begin
                if (!sts.init_done)
                begin
                    cmd.init_step = 1'b1;
                end
                else if (sts.empty)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_PASS;
                end
            end
            S_SETUP:
            begin
                cmd.blk_setup = 1'b1;
                state_next    = S_M_RD;
            end
            S_M_RD:
            begin
                state_next = S_M_CMP;
            end
            S_M_CMP:
            begin
                cmd.m_step = 1'b1;
                if (sts.merge_last)
                begin
                    cmd.blk_next = 1'b1;
                    state_next   = S_BLK;
                end
                else
                begin
                    state_next = S_M_RD;
                end
            end
            S_BLK:
            begin
                if (sts.blk_lt_n)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.pass_end = 1'b1;
                    state_next   = S_PASS;
                end
            end
            S_PASS:
            begin
                if (sts.width_lt_n)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.k_start = 1'b1;
                    state_next  = S_K_RD;
                end
            end
            S_K_RD:
            begin
                state_next = S_K_CHK;
            end
            S_K_CHK:
            begin
                cmd.k_latch = 1'b1;
                if (!sts.edge_skip)
                begin
                    state_next = S_F_RD;
                end
                else if (sts.j_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_K_RD;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (sts.par_self)
                begin
                    cmd.c_start = 1'b1;
                    state_next  = S_C_RD;
                end
                else
                begin
                    cmd.f_step = 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_C_RD:
            begin
                state_next = S_C_CHK;
            end
            S_C_CHK:
            begin
                if (!sts.par_root)
                begin
                    cmd.c_step = 1'b1;
                    state_next = S_C_RD;
                end
                else if (!sts.sel)
                begin
                    cmd.f_second = 1'b1;
                    state_next   = S_F_RD;
                end
                else
                begin
                    state_next = S_UNION;
                end
            end
            S_UNION:
            begin
                cmd.unite = 1'b1;
                if (sts.tree_full || sts.j_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_K_RD;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/kmst_dp.sv
// ----------------------------------------------------------------------------
// kmst_dp
// Datapath: edge store ping-pong buffers, merge pointers, parent table,
// running sums and the vertex count register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_dp
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [NV_W-1:0]    cfg_wdata,
    input  wire logic               mode,
    input  wire logic [VTX_W-1:0]   edge_from,
    input  wire logic [VTX_W-1:0]   edge_to,
    input  wire logic [WIN_W-1:0]   weight,
    input  wire kmst_cmd_t          cmd,
    output kmst_sts_t               sts,
    output logic [COST_W-1:0]       old_cost,
    output logic [COST_W-1:0]       tree_cost,
    output logic [TAKEN_W-1:0]      edges_taken
);

    localparam int VB = $clog2(MAX_VERTICES);
    localparam int EB = $clog2(MAX_EDGES);
    localparam int CW = EB + 1;
    localparam int WW = EB + 2;
    localparam int NW = VB + 1;
    localparam int RW = 2 * VB + WEIGHT_BITS;

    logic [NV_W-1:0]        nv_reg;
    logic [CW-1:0]          cnt_reg;
    logic [COST_W-1:0]      old_sum_reg;
    logic [COST_W-1:0]      cost_reg;
    logic [VB-1:0]          taken_reg;
    logic [NW-1:0]          i_reg;
    logic [WW-1:0]          blk_reg;
    logic [WW-1:0]          width_reg;
    logic                   src_sel_reg;
    logic [CW-1:0]          a_reg;
    logic [CW-1:0]          b_reg;
    logic [CW-1:0]          k_reg;
    logic [CW-1:0]          mid_reg;
    logic [CW-1:0]          hi_reg;
    logic [VB-1:0]          to_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [VB-1:0]          ptr_reg;
    logic [VB-1:0]          start_reg;
    logic [VB-1:0]          root_reg;
    logic [VB-1:0]          root_a_reg;
    logic                   sel_reg;

    logic [RW-1:0] mem_a [MAX_EDGES];
    logic [RW-1:0] mem_b [MAX_EDGES];
    logic [VB-1:0] par_mem [MAX_VERTICES];
    logic [RW-1:0] ra0_reg, ra1_reg, rb0_reg, rb1_reg;
    logic [VB-1:0] pr_reg;

    logic [WEIGHT_BITS-1:0] wm;
    logic                   ep_ok;
    logic                   load_wr;
    logic [VB-1:0]          from_m1;
    logic [VB-1:0]          to_m1;
    logic [RW-1:0]          rec_in;
    logic [NW-1:0]          nv_eff;
    logic [RW-1:0]          r0, r1, m_rec;
    logic [WEIGHT_BITS-1:0] r0_w, r1_w;
    logic [VB-1:0]          r0_from, r0_to;
    logic                   take_b;
    logic                   wr_a_en, wr_b_en;
    logic [EB-1:0]          wr_a_addr;
    logic [RW-1:0]          wr_a_data;
    logic                   roots_differ;
    logic                   p_we;
    logic [VB-1:0]          p_wa, p_wd;
    logic [WW-1:0]          sum_w, sum_2w;

    // ---- load path
    assign wm      = WEIGHT_BITS'(weight);
    assign ep_ok   = (edge_from != '0) && (edge_to != '0)
                   && (32'(edge_from) <= 32'(MAX_VERTICES))
                   && (32'(edge_to) <= 32'(MAX_VERTICES));
    assign load_wr = cmd.load && mode && ep_ok && (cnt_reg < CW'(MAX_EDGES));
    assign from_m1 = VB'(32'(edge_from) - 32'd1);
    assign to_m1   = VB'(32'(edge_to) - 32'd1);
    assign rec_in  = {from_m1, to_m1, wm};

    assign nv_eff = (32'(nv_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(nv_reg);

    // ---- edge buffers, src_sel_reg set means buffer b holds the source run
    assign r0      = src_sel_reg ? rb0_reg : ra0_reg;
    assign r1      = src_sel_reg ? rb1_reg : ra1_reg;
    assign r0_w    = r0[WEIGHT_BITS-1:0];
    assign r1_w    = r1[WEIGHT_BITS-1:0];
    assign r0_to   = r0[WEIGHT_BITS +: VB];
    assign r0_from = r0[WEIGHT_BITS+VB +: VB];

    // stable merge: right run wins on a strictly smaller weight or once the left run is used up
    assign take_b = (b_reg < hi_reg) && ((a_reg >= mid_reg) || (r1_w < r0_w));
    assign m_rec  = take_b ? r1 : r0;

    assign wr_a_en   = load_wr || (cmd.m_step && src_sel_reg);
    assign wr_a_addr = load_wr ? cnt_reg[EB-1:0] : k_reg[EB-1:0];
    assign wr_a_data = load_wr ? rec_in : m_rec;
    assign wr_b_en   = cmd.m_step && !src_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[wr_a_addr] <= wr_a_data;
        end
        ra0_reg <= mem_a[a_reg[EB-1:0]];
        ra1_reg <= mem_a[b_reg[EB-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
        begin
            mem_b[k_reg[EB-1:0]] <= m_rec;
        end
        rb0_reg <= mem_b[a_reg[EB-1:0]];
        rb1_reg <= mem_b[b_reg[EB-1:0]];
    end

    // ---- parent table
    assign roots_differ = (root_a_reg != root_reg);
    assign p_we = cmd.init_step || cmd.c_step || (cmd.unite && roots_differ);
    assign p_wa = cmd.init_step ? i_reg[VB-1:0] : (cmd.c_step ? ptr_reg : root_a_reg);
    assign p_wd = cmd.init_step ? i_reg[VB-1:0] : root_reg;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            par_mem[p_wa] <= p_wd;
        end
        pr_reg <= par_mem[ptr_reg];
    end

    assign sum_w  = blk_reg + width_reg;
    assign sum_2w = blk_reg + (width_reg << 1);

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg      <= NV_RESET;
            cnt_reg     <= '0;
            old_sum_reg <= '0;
            cost_reg    <= '0;
            taken_reg   <= '0;
            i_reg       <= '0;
            blk_reg     <= '0;
            width_reg   <= '0;
            src_sel_reg <= 1'b0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            sel_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nv_reg <= cfg_wdata;
            end
            if (cmd.load && !mode)
            begin
                old_sum_reg <= old_sum_reg + COST_W'(wm);
            end
            if (load_wr)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.init_start)
            begin
                i_reg       <= '0;
                blk_reg     <= '0;
                width_reg   <= WW'(1);
                src_sel_reg <= 1'b0;
                cost_reg    <= '0;
                taken_reg   <= '0;
            end
            if (cmd.init_step)
            begin
                i_reg <= i_reg + NW'(1);
            end
            if (cmd.blk_setup)
            begin
                a_reg   <= CW'(blk_reg);
                b_reg   <= (sum_w < WW'(cnt_reg)) ? CW'(sum_w) : cnt_reg;
                k_reg   <= CW'(blk_reg);
                mid_reg <= (sum_w < WW'(cnt_reg)) ? CW'(sum_w) : cnt_reg;
                hi_reg  <= (sum_2w < WW'(cnt_reg)) ? CW'(sum_2w) : cnt_reg;
            end
            if (cmd.m_step)
            begin
                k_reg <= k_reg + CW'(1);
                if (take_b)
                begin
                    b_reg <= b_reg + CW'(1);
                end
                else
                begin
                    a_reg <= a_reg + CW'(1);
                end
            end
            if (cmd.blk_next)
            begin
                blk_reg <= sum_2w;
            end
            if (cmd.pass_end)
            begin
                width_reg   <= width_reg << 1;
                blk_reg     <= '0;
                src_sel_reg <= !src_sel_reg;
            end
            if (cmd.k_start)
            begin
                a_reg <= '0;
            end
            if (cmd.j_next)
            begin
                a_reg <= a_reg + CW'(1);
            end
            if (cmd.k_latch)
            begin
                sel_reg <= 1'b0;
            end
            if (cmd.f_second)
            begin
                sel_reg <= 1'b1;
            end
            if (cmd.unite && roots_differ)
            begin
                cost_reg  <= cost_reg + COST_W'(w_reg);
                taken_reg <= taken_reg + VB'(1);
            end
            if (cmd.emit)
            begin
                cnt_reg     <= '0;
                old_sum_reg <= '0;
            end
        end
    end

    // ---- walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.k_latch)
        begin
            to_reg    <= r0_to;
            w_reg     <= r0_w;
            ptr_reg   <= r0_from;
            start_reg <= r0_from;
        end
        if (cmd.f_step)
        begin
            ptr_reg <= pr_reg;
        end
        if (cmd.c_start)
        begin
            root_reg <= ptr_reg;
            ptr_reg  <= start_reg;
        end
        if (cmd.c_step)
        begin
            ptr_reg <= pr_reg;
        end
        if (cmd.f_second)
        begin
            root_a_reg <= root_reg;
            ptr_reg    <= to_reg;
            start_reg  <= to_reg;
        end
    end

    // ---- status
    always_comb
    begin
        sts.init_done  = (i_reg == nv_eff);
        sts.empty      = (nv_eff == '0) || (cnt_reg == '0);
        sts.blk_lt_n   = (blk_reg < WW'(cnt_reg));
        sts.width_lt_n = (width_reg < WW'(cnt_reg));
        sts.merge_last = ((k_reg + CW'(1)) == hi_reg);
        sts.j_last     = ((a_reg + CW'(1)) == cnt_reg);
        sts.edge_skip  = ({1'b0, r0_from} >= nv_eff) || ({1'b0, r0_to} >= nv_eff);
        sts.par_self   = (pr_reg == ptr_reg);
        sts.par_root   = (pr_reg == root_reg);
        sts.sel        = sel_reg;
        sts.tree_full  = roots_differ
                       && (({1'b0, taken_reg} + NW'(1)) == (nv_eff - NW'(1)));
    end

    assign old_cost    = old_sum_reg;
    assign tree_cost   = cost_reg;
    assign edges_taken = TAKEN_W'(taken_reg);

endmodule

`default_nettype wire

>>> hdl/kruskal_mst_cost.sv
// ----------------------------------------------------------------------------
// kruskal_mst_cost
// Minimum spanning cost over loaded candidate edges, plus existing-edge cost.
// ----------------------------------------------------------------------------
// Edges load one item per clock while busy is low. The item with last_edge set
// starts the computation: busy rises and stays high until the single result is
// shown for one cycle on done. After the last item the block sets up the
// parent table (num_vertices capped at the vertex limit), then runs
// ceil(log2 n) merge passes over the n stored edges through the edge buffer
// read ports, leaves the sort, then walks the sorted edges until the tree is
// full: for each edge whose endpoints are in range, both roots are found by
// parent-table hops and the two trees are joined if they differ; the result
// is shown last. The parent table read port sets the walk speed. The receiver
// must take the result in the cycle done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_mst_cost
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [NV_W-1:0]    cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [VTX_W-1:0]   edge_from,
    input  wire logic [VTX_W-1:0]   edge_to,
    input  wire logic [WIN_W-1:0]   weight,
    input  wire logic               last_edge,
    output logic                    done,
    output logic [COST_W-1:0]       old_cost,
    output logic [COST_W-1:0]       tree_cost,
    output logic [TAKEN_W-1:0]      edges_taken
);

    kmst_cmd_t cmd;
    kmst_sts_t sts;

    kmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_edge (last_edge),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    kmst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mode        (mode),
        .edge_from   (edge_from),
        .edge_to     (edge_to),
        .weight      (weight),
        .cmd         (cmd),
        .sts         (sts),
        .old_cost    (old_cost),
        .tree_cost   (tree_cost),
        .edges_taken (edges_taken)
    );

endmodule

`default_nettype wire

>>> hdl/kmst_chk.sv
// ----------------------------------------------------------------------------
// kmst_chk
// Port-level checks of the start/busy/done sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_edge,
    input wire logic done
);

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a result only appears while the block is busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_edge) |=> busy)
        else $error("last item did not start computation");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_edge) |=> !busy)
        else $error("plain item made block busy");

endmodule

bind kruskal_mst_cost kmst_chk u_kmst_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_edge (last_edge),
    .done      (done)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for kruskal_mst_cost: directed graphs with typed costs,
// then random graphs checked against an in-bench spanning-forest calculator.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import kmst_pkg::*;
();

    localparam int MAXV = DEF_MAX_VERTICES;
    localparam int MAXE = DEF_MAX_EDGES;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [COST_W-1:0]  old_c;
        logic [COST_W-1:0]  tree_c;
        logic [TAKEN_W-1:0] taken;
    } cost_t;

    typedef struct {
        bit              is_cfg;
        bit [NV_W-1:0]   nv;
        bit              md;
        bit [VTX_W-1:0]  vf;
        bit [VTX_W-1:0]  vt;
        bit [WIN_W-1:0]  w;
        bit              lst;
        bit              chk;
        bit [31:0]       e_old;
        bit [31:0]       e_tree;
        bit [9:0]        e_taken;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [NV_W-1:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic mode = 1'b0;
    logic [VTX_W-1:0] edge_from = '0;
    logic [VTX_W-1:0] edge_to = '0;
    logic [WIN_W-1:0] weight = '0;
    logic last_edge = 1'b0;
    logic done;
    logic [COST_W-1:0] old_cost;
    logic [COST_W-1:0] tree_cost;
    logic [TAKEN_W-1:0] edges_taken;

    // model of the block
    bit [NV_W-1:0] m_nv = NV_RESET;
    int unsigned   st_from [MAXE];
    int unsigned   st_to [MAXE];
    int unsigned   st_w [MAXE];
    int unsigned   st_count = 0;
    bit [31:0]     old_sum = 0;
    int unsigned   uf_parent [MAXV];
    int unsigned   edge_order [MAXE];

    cost_t pending_costs [$];
    int    errors = 0;
    int    graphs_done = 0;
    int    items_sent = 0;
    longint cycles = 0;

    always #1 clk = ~clk;

    kruskal_mst_cost DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .mode(mode), .edge_from(edge_from),
        .edge_to(edge_to), .weight(weight), .last_edge(last_edge), .done(done),
        .old_cost(old_cost), .tree_cost(tree_cost), .edges_taken(edges_taken)
    );

    function automatic int unsigned uf_root(int unsigned x);
        int unsigned r;
        int unsigned nxt;
        r = x;
        while (uf_parent[r] != r) r = uf_parent[r];
        while (uf_parent[x] != r)
        begin
            nxt = uf_parent[x];
            uf_parent[x] = r;
            x = nxt;
        end
        return r;
    endfunction

    // loads one edge; on the closing edge returns the spanning forest cost
    function automatic bit mst_absorb(bit md, int unsigned vf, int unsigned vt,
                                      int unsigned w, bit lst, output cost_t res);
        int unsigned nv;
        int unsigned i;
        int unsigned j;
        int unsigned key;
        int unsigned a;
        int unsigned b;
        int unsigned e;
        int unsigned taken;
        bit [31:0] cost;
        res = '0;
        if (!md)
            old_sum += w;
        else if (vf >= 1 && vt >= 1 && vf <= MAXV && vt <= MAXV && st_count < MAXE)
        begin
            st_from[st_count] = vf - 1;
            st_to[st_count] = vt - 1;
            st_w[st_count] = w;
            st_count++;
        end
        if (!lst) return 1'b0;
        nv = (m_nv > MAXV) ? MAXV : m_nv;
        taken = 0;
        cost = 0;
        for (i = 0; i < nv; i++) uf_parent[i] = i;
        // insertion sort of edge indices by weight
        for (i = 0; i < st_count; i++)
        begin
            key = i;
            j = i;
            while (j > 0 && st_w[edge_order[j-1]] > st_w[key])
            begin
                edge_order[j] = edge_order[j-1];
                j--;
            end
            edge_order[j] = key;
        end
        if (nv > 0)
        begin
            for (i = 0; i < st_count; i++)
            begin
                e = edge_order[i];
                if (st_from[e] >= nv || st_to[e] >= nv) continue;
                a = uf_root(st_from[e]);
                b = uf_root(st_to[e]);
                if (a != b)
                begin
                    uf_parent[a] = b;
                    cost += st_w[e];
                    taken++;
                    if (taken == nv - 1) break;
                end
            end
        end
        res.old_c = old_sum;
        res.tree_c = cost;
        res.taken = taken[TAKEN_W-1:0];
        st_count = 0;
        old_sum = 0;
        return 1'b1;
    endfunction

    task automatic send_edge(bit md, bit [VTX_W-1:0] vf, bit [VTX_W-1:0] vt,
                             bit [WIN_W-1:0] w, bit lst, int gap,
                             bit chk, cost_t typed);
        cost_t res;
        repeat (gap) @(negedge clk);
        start = 1'b1;
        mode = md;
        edge_from = vf;
        edge_to = vt;
        weight = w;
        last_edge = lst;
        do @(posedge clk); while (busy);
        if (mst_absorb(md, vf, vt, w, lst, res))
            pending_costs.insert(pending_costs.size(), chk ? typed : res);
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_nv(bit [NV_W-1:0] v);
        while (pending_costs.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        m_nv = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // results cannot be held off, so every done pulse is checked here
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_costs.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result old=%0d tree=%0d taken=%0d",
                                           old_cost, tree_cost, edges_taken);
            end
            else
            begin
                if (pending_costs[0] != {old_cost, tree_cost, edges_taken})
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp old=%0d tree=%0d taken=%0d got %0d %0d %0d",
                                 pending_costs[0].old_c, pending_costs[0].tree_c,
                                 pending_costs[0].taken, old_cost, tree_cost, edges_taken);
                end
                void'(pending_costs.pop_front());
                graphs_done++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("kruskal_mst_cost regression: fail");
            $finish;
        end
    end

    row_t directed [] = '{
        // empty graph right after reset
        '{0, 0, 0, 1, 1, 0, 1, 1, 0, 0, 0},
        // existing edges only, heaviest weight
        '{0, 0, 0, 1, 2, 16'hffff, 0, 0, 0, 0, 0},
        '{0, 0, 0, 1, 2, 16'hffff, 1, 1, 131070, 0, 0},
        // parallel edges between the outermost vertices
        '{0, 0, 1, 1, 1024, 16'hffff, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1024, 1, 0, 1, 1, 0, 0, 1},
        // self-loop
        '{0, 0, 1, 5, 5, 7, 1, 1, 0, 0, 0},
        // endpoints out of range dropped at load
        '{0, 0, 1, 0, 3, 9, 0, 0, 0, 0, 0},
        '{0, 0, 1, 3, 2047, 9, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1025, 1, 5, 0, 0, 0, 0, 0},
        '{0, 0, 1, 2, 3, 4, 1, 1, 0, 4, 1},
        // equal weights on a triangle, mixed with an existing edge
        '{0, 0, 1, 1, 2, 10, 0, 0, 0, 0, 0},
        '{0, 0, 0, 7, 8, 33, 0, 0, 0, 0, 0},
        '{0, 0, 1, 2, 3, 10, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 3, 10, 1, 1, 33, 20, 2},
        // no vertices: nothing taken
        '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 2, 3, 1, 1, 0, 0, 0},
        // register above the vertex limit clamps
        '{1, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 1024, 3, 1, 1, 0, 3, 1},
        // endpoint beyond the vertex count skipped, early stop once the tree spans all vertices
        '{1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 4, 1, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 2, 5, 0, 0, 0, 0, 0},
        '{0, 0, 1, 2, 3, 6, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 3, 7, 1, 1, 0, 11, 2},
        // single vertex
        '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 1, 1, 1, 2, 1, 1, 0, 0, 0}
    };

    initial
    begin
        int i;
        int n;
        int gap_max;
        int nv_eff;
        bit [VTX_W-1:0] vf;
        bit [VTX_W-1:0] vt;
        bit [WIN_W-1:0] w;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
                write_nv(directed[k].nv);
            else
                send_edge(directed[k].md, directed[k].vf, directed[k].vt, directed[k].w,
                          directed[k].lst, $urandom_range(0, 2), directed[k].chk,
                          {directed[k].e_old, directed[k].e_tree, directed[k].e_taken});
        end

        while (items_sent < 1050)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: write_nv(0);
                    1: write_nv(1);
                    2: write_nv(1024);
                    3: write_nv($urandom_range(1025, 2047));
                    default: write_nv($urandom_range(2, 40));
                endcase
            end
            nv_eff = (m_nv == 0) ? 4 : ((m_nv > MAXV) ? MAXV : m_nv);
            if (nv_eff > 40 && $urandom_range(0, 1)) nv_eff = 40;
            n = $urandom_range(1, 40);
            gap_max = $urandom_range(0, 2) == 0 ? 0 : 9;
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    vf = $urandom_range(0, 2047);
                    vt = $urandom_range(0, 2047);
                end
                else
                begin
                    vf = $urandom_range(1, nv_eff);
                    vt = $urandom_range(1, nv_eff);
                end
                w = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 15);
                send_edge($urandom_range(0, 4) != 0, vf, vt, w, i == n - 1,
                          $urandom_range(0, gap_max), 1'b0, '0);
            end
        end

        while (pending_costs.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("checked %0d graphs: directed corner graphs and random graphs",
                 graphs_done);
        $display("over several vertex counts with random start gaps");
        if (errors == 0 && pending_costs.size() == 0)
            $display("kruskal_mst_cost regression: pass");
        else
        begin
            $display("%0d mismatches", errors);
            $display("kruskal_mst_cost regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
